// File: hdl/vsid_pkg.sv
// ----------------------------------------------------------------------------
// vsid_pkg
// Types and constants shared by the vertex-program instruction decoder stages.
// ----------------------------------------------------------------------------
package vsid_pkg;

  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 9;
  localparam int DESC_W   = 20;
  localparam int SLOTS    = 3;
  localparam int IN_W     = 96;
  localparam int OUT_W    = 128;

  // Vector opcodes that matter to the decoder.
  localparam logic [3:0] MAC_NONE = 4'd0;
  localparam logic [3:0] MAC_MUL  = 4'd2;
  localparam logic [3:0] MAC_ADD  = 4'd3;
  localparam logic [3:0] MAC_MAD  = 4'd4;
  localparam logic [3:0] MAC_SGE  = 4'd12;
  localparam logic [3:0] MAC_ARL  = 4'd13;

  localparam logic [2:0] ILU_NONE = 3'd0;

  // Operand multiplexer codes.
  localparam logic [1:0] MUX_BAD   = 2'd0;
  localparam logic [1:0] MUX_TEMP  = 2'd1;
  localparam logic [1:0] MUX_INPUT = 2'd2;
  localparam logic [1:0] MUX_CONST = 2'd3;

  // Destination kinds of the vector unit.
  localparam logic [1:0] DEST_NONE = 2'd0;
  localparam logic [1:0] DEST_TEMP = 2'd1;
  localparam logic [1:0] DEST_ADDR = 2'd2;

  // Raw operand fields as found in the instruction.
  typedef struct packed {
    logic [1:0] mux;
    logic       neg;
    logic [7:0] swz;
    logic [3:0] reg_idx;
  } raw_opnd_t;

  // Stage one: fields pulled out of the instruction words.
  typedef struct packed {
    logic [3:0]        mac_op;
    logic              mac_ok;
    logic              bad_mac;
    logic              paired;
    logic              need_b;
    logic              need_c;
    logic [2:0]        ilu_op;
    logic [ADDR_W-1:0] cst;
    logic [3:0]        vin;
    raw_opnd_t         a;
    raw_opnd_t         b;
    raw_opnd_t         c;
    logic [3:0]        rout;
    logic [3:0]        mac_mask;
    logic [3:0]        ilu_mask;
    logic [14:0]       out_dest;
    logic              uses_addr_index;
    logic              is_final;
  } fields_t;

  // Stage two: operand descriptors and destinations.
  typedef struct packed {
    logic [3:0]        mac_op;
    logic              mac_ok;
    logic              bad_mac;
    logic              need_b;
    logic              need_c;
    logic [9:0]        mac_dest;
    logic [DESC_W-1:0] opa;
    logic [DESC_W-1:0] opb;
    logic [DESC_W-1:0] opc;
    logic              a_bad;
    logic              b_bad;
    logic              c_bad;
    logic [2:0]        ilu_op;
    logic [7:0]        ilu_dest;
    logic [14:0]       out_dest;
    logic              uses_addr_index;
    logic              is_final;
  } opnds_t;

  // Final decoded instruction.
  typedef struct packed {
    logic [3:0]              mac_opcode;
    logic [9:0]              mac_dest;
    logic [1:0]              mac_operand_count;
    logic [SLOTS*DESC_W-1:0] mac_operands;
    logic [2:0]              ilu_opcode;
    logic [7:0]              ilu_dest;
    logic [DESC_W-1:0]       ilu_operand;
    logic [14:0]             out_dest;
    logic                    uses_addr_index;
    logic                    is_final;
    logic                    bad_mac;
    logic                    bad_mux;
  } result_t;

endpackage

// File: hdl/vsid_field_extract.sv
// ----------------------------------------------------------------------------
// vsid_field_extract
// First pipeline stage: splits the instruction words into fields and
// classifies the vector opcode.
// ----------------------------------------------------------------------------
module vsid_field_extract (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          word_one,
  input  logic [31:0]          word_two,
  input  logic [31:0]          word_three,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vsid_pkg::fields_t    out_data
);
  import vsid_pkg::*;

  fields_t nxt;
  logic    valid;

  always_comb begin
    nxt = '0;
    nxt.ilu_op   = word_one[27:25];
    nxt.mac_op   = word_one[24:21];
    nxt.mac_ok   = (nxt.mac_op != MAC_NONE) && (nxt.mac_op <= MAC_ARL);
    nxt.bad_mac  = nxt.mac_op > MAC_ARL;
    nxt.paired   = (nxt.mac_op != MAC_NONE) && (nxt.ilu_op != ILU_NONE);
    nxt.need_b   = (nxt.mac_op == MAC_MUL) ||
                   ((nxt.mac_op >= MAC_MAD) && (nxt.mac_op <= MAC_SGE));
    nxt.need_c   = (nxt.mac_op == MAC_ADD) || (nxt.mac_op == MAC_MAD);
    // The constant index rebases to -96..159 by a plain subtraction mod 512.
    nxt.cst      = {1'b0, word_one[20:13]} - ADDR_W'(96);
    nxt.vin      = word_one[12:9];
    nxt.a        = '{mux: word_two[27:26], neg: word_one[8], swz: word_one[7:0],
                     reg_idx: word_two[31:28]};
    nxt.b        = '{mux: word_two[12:11], neg: word_two[25], swz: word_two[24:17],
                     reg_idx: word_two[16:13]};
    nxt.c        = '{mux: word_three[29:28], neg: word_two[10], swz: word_two[9:2],
                     reg_idx: {word_two[1:0], word_three[31:30]}};
    nxt.rout     = word_three[23:20];
    nxt.mac_mask = word_three[27:24];
    nxt.ilu_mask = word_three[19:16];
    nxt.out_dest[0]    = word_three[11];
    nxt.out_dest[9:1]  = word_three[11] ? {5'b0, word_three[6:3]}
                                        : ({1'b0, word_three[10:3]} - ADDR_W'(96));
    nxt.out_dest[13:10] = word_three[15:12];
    nxt.out_dest[14]    = word_three[2];
    nxt.uses_addr_index = word_three[1];
    nxt.is_final        = word_three[0];
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// File: hdl/vsid_operand_build.sv
// ----------------------------------------------------------------------------
// vsid_operand_build
// Second pipeline stage: builds the operand descriptors and the vector and
// scalar destinations.
// ----------------------------------------------------------------------------
module vsid_operand_build (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vsid_pkg::fields_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vsid_pkg::opnds_t     out_data
);
  import vsid_pkg::*;

  opnds_t nxt;
  logic   valid;

  // Selects the address by mux, repacks the swizzle with x in the low bits.
  function automatic logic [DESC_W-1:0] build_desc(raw_opnd_t op,
                                                    logic [3:0] vin,
                                                    logic [ADDR_W-1:0] cst);
    logic [ADDR_W-1:0] addr;
    logic [7:0]        swz;
    addr = '0;
    unique case (op.mux)
      MUX_TEMP:  addr = {5'b0, op.reg_idx};
      MUX_INPUT: addr = {5'b0, vin};
      MUX_CONST: addr = cst;
      default:   addr = '0;
    endcase
    swz = {op.swz[1:0], op.swz[3:2], op.swz[5:4], op.swz[7:6]};
    return {swz, op.neg, addr, op.mux};
  endfunction

  always_comb begin
    nxt = '0;
    nxt.mac_ok  = in_data.mac_ok;
    nxt.bad_mac = in_data.bad_mac;
    nxt.need_b  = in_data.need_b;
    nxt.need_c  = in_data.need_c;
    nxt.mac_op  = in_data.mac_ok ? in_data.mac_op : MAC_NONE;
    if (!in_data.mac_ok || (in_data.paired && in_data.rout == 4'd1)) begin
      nxt.mac_dest = '0;
    end else if (in_data.mac_op == MAC_ARL) begin
      nxt.mac_dest = {4'b1000, 4'd0, DEST_ADDR};
    end else begin
      nxt.mac_dest = {in_data.mac_mask, in_data.rout, DEST_TEMP};
    end
    nxt.opa   = build_desc(in_data.a, in_data.vin, in_data.cst);
    nxt.opb   = build_desc(in_data.b, in_data.vin, in_data.cst);
    nxt.opc   = build_desc(in_data.c, in_data.vin, in_data.cst);
    nxt.a_bad = in_data.a.mux == MUX_BAD;
    nxt.b_bad = in_data.b.mux == MUX_BAD;
    nxt.c_bad = in_data.c.mux == MUX_BAD;
    nxt.ilu_op = in_data.ilu_op;
    if (in_data.ilu_op != ILU_NONE) begin
      nxt.ilu_dest = {in_data.ilu_mask, in_data.paired ? 4'd1 : in_data.rout};
    end else begin
      nxt.ilu_dest = '0;
    end
    nxt.out_dest        = in_data.out_dest;
    nxt.uses_addr_index = in_data.uses_addr_index;
    nxt.is_final        = in_data.is_final;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// File: hdl/vsid_slot_pack.sv
// ----------------------------------------------------------------------------
// vsid_slot_pack
// Third pipeline stage: places the operands into slots from slot zero upward,
// counts them and gathers the bad-mux flag.
// ----------------------------------------------------------------------------
module vsid_slot_pack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vsid_pkg::opnds_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vsid_pkg::result_t    out_data
);
  import vsid_pkg::*;

  result_t nxt;
  logic    valid;
  logic    ilu_on;

  always_comb begin
    nxt    = '0;
    ilu_on = in_data.ilu_op != ILU_NONE;
    nxt.mac_opcode = in_data.mac_op;
    nxt.mac_dest   = in_data.mac_dest;
    if (in_data.mac_ok) begin
      nxt.mac_operands[DESC_W-1:0] = in_data.opa;
      if (in_data.need_b) begin
        nxt.mac_operands[2*DESC_W-1:DESC_W] = in_data.opb;
        if (in_data.need_c) begin
          nxt.mac_operands[3*DESC_W-1:2*DESC_W] = in_data.opc;
        end
      end else if (in_data.need_c) begin
        nxt.mac_operands[2*DESC_W-1:DESC_W] = in_data.opc;
      end
      nxt.mac_operand_count = 2'd1 + 2'(in_data.need_b) + 2'(in_data.need_c);
    end
    nxt.ilu_opcode  = in_data.ilu_op;
    nxt.ilu_dest    = in_data.ilu_dest;
    nxt.ilu_operand = ilu_on ? in_data.opc : '0;
    nxt.out_dest        = in_data.out_dest;
    nxt.uses_addr_index = in_data.uses_addr_index;
    nxt.is_final        = in_data.is_final;
    nxt.bad_mac         = in_data.bad_mac;
    nxt.bad_mux = (in_data.mac_ok && (in_data.a_bad ||
                                      (in_data.need_b && in_data.b_bad) ||
                                      (in_data.need_c && in_data.c_bad))) ||
                  (ilu_on && in_data.c_bad);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// File: hdl/vertex_shader_instruction_decode_core.sv
// ----------------------------------------------------------------------------
// vertex_shader_instruction_decode_core
// Data path: an instruction is registered in stage one, stage two and stage
// three in that order; the stage three register drives the master side.
// Throughput: one instruction per cycle unless m_tready stalls; each of the
// three register stages holds one instruction and advances when the next has room.
// Reset: synchronous rst empties all three stages; payload is not cleared.
// ----------------------------------------------------------------------------
module vertex_shader_instruction_decode_core (
  input  logic         clk,
  input  logic         rst,
  // Slave side: one instruction per transfer.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0 up: word_one[31:0], word_two[63:32], word_three[95:64].
  input  logic [95:0]  s_tdata,
  // Master side: one decoded instruction per transfer.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0 up: mac_opcode[3:0], mac_dest[13:4],
  // mac_operand_count[15:14], mac_operands[75:16], ilu_opcode[78:76],
  // ilu_dest[86:79], ilu_operand[106:87], out_dest[121:107],
  // uses_addr_index[122], is_final[123], bad_mac[124], bad_mux[125],
  // zero fill[127:126].
  output logic [127:0] m_tdata
);
  import vsid_pkg::*;

  // Stage handshakes. Each stage is ready when it is empty or when the stage
  // after it takes its contents in the same cycle, so a stall ripples back
  // without dropping or duplicating a transfer.
  fields_t f_data;
  opnds_t  o_data;
  result_t r_data;
  logic    f_valid, f_ready;
  logic    o_valid, o_ready;

  // Stage one: field extraction, constant rebasing, opcode classification.
  vsid_field_extract u_extract (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .word_one   (s_tdata[31:0]),
    .word_two   (s_tdata[63:32]),
    .word_three (s_tdata[95:64]),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_data   (f_data)
  );

  // Stage two: operand descriptors and destinations, including the rule
  // that a paired vector op writing R1 is dropped and a paired scalar op
  // always writes R1.
  vsid_operand_build u_build (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (o_valid),
    .out_ready (o_ready),
    .out_data  (o_data)
  );

  // Stage three: slot packing, operand count and the bad-mux flag. Its
  // register is the output register of the block.
  vsid_slot_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (o_valid),
    .in_ready  (o_ready),
    .in_data   (o_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (r_data)
  );

  // Pack the result onto the master bus, first field in the lowest bits.
  assign m_tdata = {2'b00,
                    r_data.bad_mux,
                    r_data.bad_mac,
                    r_data.is_final,
                    r_data.uses_addr_index,
                    r_data.out_dest,
                    r_data.ilu_operand,
                    r_data.ilu_dest,
                    r_data.ilu_opcode,
                    r_data.mac_operands,
                    r_data.mac_operand_count,
                    r_data.mac_dest,
                    r_data.mac_opcode};

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams vertex-program instructions into the decoder and checks every
// decoded result, field by field, against a behavioral decode in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import vsid_pkg::*;

  // Scalar opcodes and unknown vector opcodes used by the directed cases.
  localparam logic [2:0] ILU_RCP    = 3'd2;
  localparam logic [2:0] ILU_RCC    = 3'd3;
  localparam logic [2:0] ILU_EXP    = 3'd5;
  localparam logic [2:0] ILU_LOG    = 3'd6;
  localparam logic [3:0] MAC_BAD_LO = 4'd14;
  localparam logic [3:0] MAC_BAD_HI = 4'd15;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // s_tdata from bit 0 up: word_one, word_two, word_three.
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // m_tdata from bit 0 up: mac_opcode, mac_dest, mac_operand_count,
  // mac_operands, ilu_opcode, ilu_dest, ilu_operand, out_dest,
  // uses_addr_index, is_final, bad_mac, bad_mux, zero fill.
  logic [127:0] m_tdata;

  // Instructions waiting to be sent, and decodes waiting to come back.
  logic [95:0] instr_queue[$];
  result_t     decode_queue[$];

  int instr_total    = 0;
  int accepted_count = 0;
  int result_count   = 0;
  int error_count    = 0;
  int paired_count   = 0;
  int bad_mac_count  = 0;
  int bad_mux_count  = 0;
  int send_gap       = 0;
  int recv_stall     = 0;

  vertex_shader_instruction_decode_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Constant indexes are stored with a bias of 96, so the signed range is
  // -96..159, kept as a 9-bit two's complement address.
  function automatic logic [ADDR_W-1:0] rebase_const(logic [7:0] idx);
    return {1'b0, idx} - 9'd96;
  endfunction

  // One operand descriptor. The raw swizzle has x in its top two bits; the
  // descriptor wants x in the lowest two. A bad mux leaves the address zero.
  function automatic logic [DESC_W-1:0] build_operand(logic [1:0] mux, logic neg,
                                                      logic [7:0] swz, logic [3:0] reg_idx,
                                                      logic [3:0] vin,
                                                      logic [ADDR_W-1:0] cst);
    logic [ADDR_W-1:0] addr;
    case (mux)
      MUX_TEMP:  addr = {5'b0, reg_idx};
      MUX_INPUT: addr = {5'b0, vin};
      MUX_CONST: addr = cst;
      default:   addr = '0;
    endcase
    return {swz[1:0], swz[3:2], swz[5:4], swz[7:6], neg, addr, mux};
  endfunction

  // Full decode of one instruction into the expected result.
  function automatic result_t decode_instruction(logic [95:0] instr);
    logic [31:0]       w1, w2, w3;
    logic [2:0]        ilu;
    logic [3:0]        mac, rout;
    logic [ADDR_W-1:0] cst, oaddr;
    logic [DESC_W-1:0] opa, opb, opc;
    logic              paired, bad;
    int                cnt;
    result_t           r;
    w1     = instr[31:0];
    w2     = instr[63:32];
    w3     = instr[95:64];
    ilu    = w1[27:25];
    mac    = w1[24:21];
    rout   = w3[23:20];
    cst    = rebase_const(w1[20:13]);
    opa    = build_operand(w2[27:26], w1[8], w1[7:0], w2[31:28], w1[12:9], cst);
    opb    = build_operand(w2[12:11], w2[25], w2[24:17], w2[16:13], w1[12:9], cst);
    opc    = build_operand(w3[29:28], w2[10], w2[9:2], {w2[1:0], w3[31:30]},
                           w1[12:9], cst);
    // An unknown vector opcode still counts as present for pairing.
    paired = (mac != MAC_NONE) && (ilu != ILU_NONE);
    bad    = 1'b0;
    cnt    = 0;
    r      = '0;

    if (mac != MAC_NONE && mac <= MAC_ARL) begin
      r.mac_opcode = mac;
      // When paired, R1 belongs to the scalar unit, so a vector write there
      // is dropped. Otherwise ARL writes A0.x.
      if (paired && rout == 4'd1) begin
        r.mac_dest = '0;
      end else if (mac == MAC_ARL) begin
        r.mac_dest = {4'b1000, 4'd0, DEST_ADDR};
      end else begin
        r.mac_dest = {w3[27:24], rout, DEST_TEMP};
      end
      r.mac_operands[DESC_W-1:0] = opa;
      bad = (opa[1:0] == MUX_BAD);
      cnt = 1;
      if (mac == MAC_MUL || (mac >= MAC_MAD && mac <= MAC_SGE)) begin
        r.mac_operands[DESC_W*cnt +: DESC_W] = opb;
        bad |= (opb[1:0] == MUX_BAD);
        cnt++;
      end
      if (mac == MAC_ADD || mac == MAC_MAD) begin
        r.mac_operands[DESC_W*cnt +: DESC_W] = opc;
        bad |= (opc[1:0] == MUX_BAD);
        cnt++;
      end
      r.mac_operand_count = cnt[1:0];
    end

    if (ilu != ILU_NONE) begin
      r.ilu_opcode  = ilu;
      r.ilu_dest    = {w3[19:16], paired ? 4'd1 : rout};
      r.ilu_operand = opc;
      bad |= (opc[1:0] == MUX_BAD);
    end

    // Constant-bank outputs are rebased like operands; output registers keep
    // only the low four bits of the address.
    oaddr = w3[11] ? {5'b0, w3[6:3]} : rebase_const(w3[10:3]);
    r.out_dest        = {w3[2], w3[15:12], oaddr, w3[11]};
    r.uses_addr_index = w3[1];
    r.is_final        = w3[0];
    r.bad_mac         = (mac > MAC_ARL);
    r.bad_mux         = bad;
    return r;
  endfunction

  function automatic result_t unpack_result(logic [127:0] d);
    result_t r;
    r.mac_opcode        = d[3:0];
    r.mac_dest          = d[13:4];
    r.mac_operand_count = d[15:14];
    r.mac_operands      = d[75:16];
    r.ilu_opcode        = d[78:76];
    r.ilu_dest          = d[86:79];
    r.ilu_operand       = d[106:87];
    r.out_dest          = d[121:107];
    r.uses_addr_index   = d[122];
    r.is_final          = d[123];
    r.bad_mac           = d[124];
    r.bad_mux           = d[125];
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then long. Quiet stretches
  // run with no idling at all.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("%0t: mismatch in %s on result %0d: got %h, expected %h",
             $time, what, result_count, got, want);
  endtask

  task automatic add_instr(logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
    instr_queue.insert(instr_queue.size(), {w3, w2, w1});
    instr_total++;
  endtask

  // Driver: presents the next instruction once the current one has been
  // transferred and any chosen gap has elapsed.
  always @(posedge clk) begin : drive_proc
    logic valid_n;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_queue.insert(decode_queue.size(), decode_instruction(s_tdata));
        accepted_count++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          valid_n = 1'b0;
        end else if (instr_queue.size() > 0) begin
          s_tdata  <= instr_queue.pop_front();
          valid_n  = 1'b1;
          send_gap = pick_gap((accepted_count % 400) >= 300);
        end else begin
          valid_n = 1'b0;
        end
        s_tvalid <= valid_n;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expected decode
  // and throttles m_tready with random stalls.
  always @(posedge clk) begin : watch_proc
    result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = unpack_result(m_tdata);
        if (decode_queue.size() == 0) begin
          report_mismatch("unexpected transfer", m_tdata[63:0], '0);
        end else begin
          want = decode_queue.pop_front();
          if (got.mac_opcode !== want.mac_opcode)
            report_mismatch("mac_opcode", 64'(got.mac_opcode), 64'(want.mac_opcode));
          if (got.mac_dest !== want.mac_dest)
            report_mismatch("mac_dest", 64'(got.mac_dest), 64'(want.mac_dest));
          if (got.mac_operand_count !== want.mac_operand_count)
            report_mismatch("mac_operand_count", 64'(got.mac_operand_count),
                            64'(want.mac_operand_count));
          if (got.mac_operands !== want.mac_operands)
            report_mismatch("mac_operands", 64'(got.mac_operands),
                            64'(want.mac_operands));
          if (got.ilu_opcode !== want.ilu_opcode)
            report_mismatch("ilu_opcode", 64'(got.ilu_opcode), 64'(want.ilu_opcode));
          if (got.ilu_dest !== want.ilu_dest)
            report_mismatch("ilu_dest", 64'(got.ilu_dest), 64'(want.ilu_dest));
          if (got.ilu_operand !== want.ilu_operand)
            report_mismatch("ilu_operand", 64'(got.ilu_operand), 64'(want.ilu_operand));
          if (got.out_dest !== want.out_dest)
            report_mismatch("out_dest", 64'(got.out_dest), 64'(want.out_dest));
          if (got.uses_addr_index !== want.uses_addr_index)
            report_mismatch("uses_addr_index", 64'(got.uses_addr_index),
                            64'(want.uses_addr_index));
          if (got.is_final !== want.is_final)
            report_mismatch("is_final", 64'(got.is_final), 64'(want.is_final));
          if (got.bad_mac !== want.bad_mac)
            report_mismatch("bad_mac", 64'(got.bad_mac), 64'(want.bad_mac));
          if (got.bad_mux !== want.bad_mux)
            report_mismatch("bad_mux", 64'(got.bad_mux), 64'(want.bad_mux));
          if (want.ilu_opcode != ILU_NONE && (want.mac_opcode != MAC_NONE || want.bad_mac))
            paired_count++;
          if (want.bad_mac) bad_mac_count++;
          if (want.bad_mux) bad_mux_count++;
        end
        result_count++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        if ((accepted_count % 400) < 300 && $urandom_range(0, 9) == 0)
          recv_stall = pick_gap(1'b0);
        m_tready <= (recv_stall == 0);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stim_proc
    logic [31:0] w1, w2, w3;
    int          i;

    // Directed part: empty and full words first.
    add_instr('0, '0, '0);
    add_instr('1, '1, '1);
    // Every known vector opcode on its own, with random operand fields.
    for (i = 1; i <= MAC_ARL; i++) begin
      w1 = $urandom; w2 = $urandom; w3 = $urandom;
      w1[27:25] = ILU_NONE;
      w1[24:21] = i[3:0];
      add_instr(w1, w2, w3);
    end
    // Paired MAD writing R1: the vector write must be dropped.
    w1 = $urandom; w2 = $urandom; w3 = $urandom;
    w1[27:25] = ILU_RCC; w1[24:21] = MAC_MAD; w3[23:20] = 4'd1;
    add_instr(w1, w2, w3);
    // Paired ARL: the address register is still written, the ILU takes R1.
    w1 = $urandom; w2 = $urandom; w3 = $urandom;
    w1[27:25] = ILU_LOG; w1[24:21] = MAC_ARL; w3[23:20] = 4'd5;
    add_instr(w1, w2, w3);
    // Scalar operation alone, its operand with an unknown mux.
    w1 = $urandom; w2 = $urandom; w3 = $urandom;
    w1[27:25] = ILU_EXP; w1[24:21] = MAC_NONE; w3[29:28] = MUX_BAD;
    add_instr(w1, w2, w3);
    // Unknown vector opcodes, with and without a scalar partner.
    w1 = $urandom; w2 = $urandom; w3 = $urandom;
    w1[27:25] = ILU_RCP; w1[24:21] = MAC_BAD_HI;
    add_instr(w1, w2, w3);
    w1 = $urandom; w2 = $urandom; w3 = $urandom;
    w1[27:25] = ILU_NONE; w1[24:21] = MAC_BAD_LO;
    add_instr(w1, w2, w3);
    // Constant index and output address at both ends, both output kinds.
    w1 = $urandom; w2 = $urandom; w3 = $urandom;
    w1[24:21] = MAC_MAD; w1[20:13] = 8'h00;
    w2[27:26] = MUX_CONST; w2[12:11] = MUX_CONST; w3[29:28] = MUX_CONST;
    w3[11] = 1'b0; w3[10:3] = 8'h00;
    add_instr(w1, w2, w3);
    w1[20:13] = 8'hFF; w3[11] = 1'b1; w3[10:3] = 8'hFF;
    add_instr(w1, w2, w3);

    // Random part, biased toward unpaired operations, R1 outputs and valid
    // muxes so that every decode path is visited often.
    for (i = 0; i < 1950; i++) begin
      w1 = $urandom; w2 = $urandom; w3 = $urandom;
      if ($urandom_range(0, 3) == 0) w1[27:25] = ILU_NONE;
      if ($urandom_range(0, 5) == 0) w1[24:21] = MAC_NONE;
      if ($urandom_range(0, 3) == 0) w3[23:20] = 4'd1;
      if (w2[27:26] == MUX_BAD && $urandom_range(0, 2) != 0)
        w2[27:26] = 2'($urandom_range(1, 3));
      if (w2[12:11] == MUX_BAD && $urandom_range(0, 2) != 0)
        w2[12:11] = 2'($urandom_range(1, 3));
      if (w3[29:28] == MUX_BAD && $urandom_range(0, 2) != 0)
        w3[29:28] = 2'($urandom_range(1, 3));
      add_instr(w1, w2, w3);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait until every instruction has been transferred and decoded, then
    // give the three pipeline stages time to show any stray result.
    while (accepted_count < instr_total || decode_queue.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Decoded %0d of %0d instructions: %0d paired, %0d unknown vector opcodes,",
             result_count, instr_total, paired_count, bad_mac_count);
    $display("%0d with an unknown operand mux; %0d mismatches.",
             bad_mux_count, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with all gaps and stalls.
  initial begin
    #5_000_000;
    $display("Timed out with %0d decodes outstanding.", decode_queue.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
hdl/vsid_pkg.sv
hdl/vsid_field_extract.sv
hdl/vsid_operand_build.sv
hdl/vsid_slot_pack.sv
hdl/vertex_shader_instruction_decode_core.sv
dv/testbench.sv
